### src/cross_mean_blur_rgb_assert.svh
// ----------------------------------------------------------------------------
// cross_mean_blur_rgb_assert.svh - assertion macros
// Shared concurrent assertion forms for the blur block checkers.
// ----------------------------------------------------------------------------
`ifndef CROSS_MEAN_BLUR_RGB_ASSERT_SVH
`define CROSS_MEAN_BLUR_RGB_ASSERT_SVH

// cond at one edge implies expr at the next, outside reset
`define CMB_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("cmb check failed");

// expr holds in the cycle after a reset edge
`define CMB_ASSERT_RST(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (expr)) \
        else $error("cmb reset check failed");

`endif

### src/cmb_pkg.sv
// ----------------------------------------------------------------------------
// cmb_pkg - shared types and constants
// Widths, register indexes, op codes and the command flags of the blur block.
// ----------------------------------------------------------------------------
package cmb_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int NBR_MAX    = 5;
    localparam int SUM_W      = $clog2(NBR_MAX * 255 + 1);
    localparam int CNT_W      = $clog2(NBR_MAX + 1);

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 4;

    localparam int FW_REG_W         = 12;
    localparam int FH_REG_W         = 13;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // floor(s/3) = (s*683)>>11 and floor(s/5) = (s*1639)>>13 for s <= 1275
    localparam int REC_W     = 11;
    localparam int PROD_W    = SUM_W + REC_W;
    localparam int RECIP3    = 683;
    localparam int RECIP3_SH = 11;
    localparam int RECIP5    = 1639;
    localparam int RECIP5_SH = 13;

    typedef struct packed {
        logic emit;       // produce an output pixel
        logic store;      // write the incoming pixel to the centre row
        logic has_left;
        logic has_right;
        logic has_above;
        logic has_below;
        logic last;       // final pixel of the frame
    } t_cmd_flags;

    localparam int FLAGS_W = $bits(t_cmd_flags);

endpackage

### src/cmb_ram.sv
// ----------------------------------------------------------------------------
// cmb_ram - generic simple dual port RAM
// One write port, one read port, registered read (old data on collision).
// ----------------------------------------------------------------------------
module cmb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/cmb_fifo.sv
// ----------------------------------------------------------------------------
// cmb_fifo - short command queue
// Flop based FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module cmb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + CNTW'(1);
            2'b01:   n_count = r_count - CNTW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### src/cmb_front.sv
// ----------------------------------------------------------------------------
// cmb_front - request classifier
// Holds frame size and raster position, turns requests into commands.
// ----------------------------------------------------------------------------
module cmb_front
    import cmb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [PIX_W-1:0]      i_s_axis_tdata,
    input  logic                  i_s_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_push,
    output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] o_col,
    output logic [PIX_W-1:0]      o_pix,
    output t_cmd_flags            o_flags,
    input  logic                  i_full
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    function automatic logic [WW-1:0] clamp_w(input logic [FW_REG_W-1:0] v);
        int unsigned t;
        t = 32'(v);
        if (t == 0) t = 1;
        if (t > MAX_WIDTH) t = MAX_WIDTH;
        return WW'(t);
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [FH_REG_W-1:0] v);
        int unsigned t;
        t = 32'(v);
        if (t == 0) t = 1;
        if (t > MAX_HEIGHT) t = MAX_HEIGHT;
        return HW'(t);
    endfunction

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [CW-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [HW-1:0] r_in_row, n_in_row;
    logic          r_out_above, n_out_above;

    logic cfg_wr, accept, in_col_last, out_col_last, frame_done;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = ~i_full;
    assign cfg_wr          = i_cfg_valid & o_cfg_ready;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;
    assign in_col_last     = (WW'(r_in_col) + WW'(1)) >= r_width;
    assign out_col_last    = (WW'(r_out_col) + WW'(1)) >= r_width;
    assign frame_done      = r_in_row >= r_height;
    assign o_pix           = i_s_axis_tdata;

    always_comb begin
        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_out_col   = r_out_col;
        n_out_above = r_out_above;
        o_push      = 1'b0;
        o_col       = r_in_col;
        o_flags     = '0;
        if (cfg_wr) begin
            // any write restarts the frame
            n_in_col    = '0;
            n_in_row    = '0;
            n_out_col   = '0;
            n_out_above = 1'b0;
        end else if (accept) begin
            if (i_s_axis_tuser == OP_PIXEL) begin
                if (!frame_done) begin
                    o_push            = 1'b1;
                    o_flags.emit      = (r_in_row != '0);
                    o_flags.store     = 1'b1;
                    o_flags.has_left  = (r_in_col != '0);
                    o_flags.has_right = ~in_col_last;
                    o_flags.has_above = (r_in_row > HW'(1));
                    o_flags.has_below = 1'b1;
                    if (in_col_last) begin
                        n_in_col = '0;
                        n_in_row = r_in_row + HW'(1);
                    end else begin
                        n_in_col = r_in_col + CW'(1);
                    end
                    n_out_col   = n_in_col;
                    n_out_above = (n_in_row > HW'(1));
                end
            end else if (frame_done) begin
                // flush tick drains the last row
                o_push            = 1'b1;
                o_col             = r_out_col;
                o_flags.emit      = 1'b1;
                o_flags.has_left  = (r_out_col != '0);
                o_flags.has_right = ~out_col_last;
                o_flags.has_above = r_out_above;
                o_flags.last      = out_col_last;
                if (out_col_last) begin
                    n_in_col    = '0;
                    n_in_row    = '0;
                    n_out_col   = '0;
                    n_out_above = 1'b0;
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= clamp_w(FW_REG_W'(FRAME_WIDTH_RST));
            r_height    <= clamp_h(FH_REG_W'(FRAME_HEIGHT_RST));
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_above <= 1'b0;
        end else begin
            r_in_col    <= n_in_col;
            r_in_row    <= n_in_row;
            r_out_col   <= n_out_col;
            r_out_above <= n_out_above;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_width  <= clamp_w(i_cfg_data[FW_REG_W-1:0]);
                    REG_FRAME_HEIGHT: r_height <= clamp_h(i_cfg_data[FH_REG_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

endmodule

### src/cmb_back.sv
// ----------------------------------------------------------------------------
// cmb_back - line buffer and mean datapath
// Reads the row stores, sums the cross neighbourhood, divides by the count.
// ----------------------------------------------------------------------------
module cmb_back
    import cmb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    output logic                 o_pop,
    input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] i_col,
    input  logic [PIX_W-1:0]     i_pix,
    input  t_cmd_flags           i_flags,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PIX_W-1:0]     o_data,
    output logic                 o_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // pipeline advance: whole back end stalls on a blocked output
    logic adv;
    logic [CW-1:0] rd_right;

    // stage 1: RAM data returns
    logic             r_s1_valid;
    logic [CW-1:0]    r_s1_col;
    logic [PIX_W-1:0] r_s1_pix;
    t_cmd_flags       r_s1_flags;
    logic             r_s1_byp_c, r_s1_byp_r, r_s1_byp_a;
    logic [PIX_W-1:0] r_byp_cdat, r_byp_adat, r_prev_cen;
    logic [PIX_W-1:0] ram_cen_q, ram_right_q, ram_abv_q;
    logic [PIX_W-1:0] s1_cen, s1_right, s1_abv;
    logic             cen_wr, abv_wr;
    logic [SUM_W-1:0] s1_sum [3];
    logic [CNT_W-1:0] s1_cnt;

    // stage 2: divide
    logic             r_s2_valid;
    logic [SUM_W-1:0] r_s2_sum [3];
    logic [CNT_W-1:0] r_s2_cnt;
    logic             r_s2_last;
    logic [REC_W-1:0] recip;
    logic [PROD_W-1:0] prod [3];
    logic [CH_W-1:0]  quot [3];

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_data;
    logic             r_out_last;

    assign adv      = ~r_out_valid | i_ready;
    assign o_pop    = adv & ~i_empty;
    assign rd_right = i_col + CW'(1);

    assign cen_wr = adv & r_s1_valid & r_s1_flags.store;
    assign abv_wr = adv & r_s1_valid & r_s1_flags.emit;

    cmb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_cen_a (
        .i_clk     (i_clk),
        .i_wr_en   (cen_wr),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_pix),
        .i_rd_en   (o_pop),
        .i_rd_addr (i_col),
        .o_rd_data (ram_cen_q)
    );

    // second copy of the centre row serves the right neighbour
    cmb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_cen_b (
        .i_clk     (i_clk),
        .i_wr_en   (cen_wr),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_pix),
        .i_rd_en   (o_pop),
        .i_rd_addr (rd_right),
        .o_rd_data (ram_right_q)
    );

    cmb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above (
        .i_clk     (i_clk),
        .i_wr_en   (abv_wr),
        .i_wr_addr (r_s1_col),
        .i_wr_data (s1_cen),
        .i_rd_en   (o_pop),
        .i_rd_addr (i_col),
        .o_rd_data (ram_abv_q)
    );

    // collision with the write of the same edge reads the write data
    assign s1_cen   = r_s1_byp_c ? r_byp_cdat : ram_cen_q;
    assign s1_right = r_s1_byp_r ? r_byp_cdat : ram_right_q;
    assign s1_abv   = r_s1_byp_a ? r_byp_adat : ram_abv_q;

    always_comb begin
        s1_cnt = CNT_W'(1) + CNT_W'(r_s1_flags.has_left) + CNT_W'(r_s1_flags.has_right)
               + CNT_W'(r_s1_flags.has_above) + CNT_W'(r_s1_flags.has_below);
        for (int k = 0; k < 3; k++) begin
            s1_sum[k] = SUM_W'(s1_cen[k*CH_W +: CH_W])
                + (r_s1_flags.has_left  ? SUM_W'(r_prev_cen[k*CH_W +: CH_W]) : '0)
                + (r_s1_flags.has_right ? SUM_W'(s1_right[k*CH_W +: CH_W])   : '0)
                + (r_s1_flags.has_above ? SUM_W'(s1_abv[k*CH_W +: CH_W])     : '0)
                + (r_s1_flags.has_below ? SUM_W'(r_s1_pix[k*CH_W +: CH_W])   : '0);
        end
    end

    always_comb begin
        recip = (r_s2_cnt == CNT_W'(NBR_MAX)) ? REC_W'(RECIP5) : REC_W'(RECIP3);
        for (int k = 0; k < 3; k++) begin
            prod[k] = PROD_W'(r_s2_sum[k]) * PROD_W'(recip);
            case (r_s2_cnt)
                CNT_W'(2):       quot[k] = CH_W'(r_s2_sum[k] >> 1);
                CNT_W'(3):       quot[k] = CH_W'(prod[k] >> RECIP3_SH);
                CNT_W'(4):       quot[k] = CH_W'(r_s2_sum[k] >> 2);
                CNT_W'(NBR_MAX): quot[k] = CH_W'(prod[k] >> RECIP5_SH);
                default:         quot[k] = CH_W'(r_s2_sum[k]);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid & r_s1_flags.emit;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_col   <= i_col;
            r_s1_pix   <= i_pix;
            r_s1_flags <= i_flags;
            r_s1_byp_c <= cen_wr & (r_s1_col == i_col);
            r_s1_byp_r <= cen_wr & (r_s1_col == rd_right);
            r_s1_byp_a <= abv_wr & (r_s1_col == i_col);
            r_byp_cdat <= r_s1_pix;
            r_byp_adat <= s1_cen;
            if (r_s1_valid) begin
                r_prev_cen <= s1_cen;
            end
            r_s2_sum   <= s1_sum;
            r_s2_cnt   <= s1_cnt;
            r_s2_last  <= r_s1_flags.last;
            r_out_data <= {quot[2], quot[1], quot[0]};
            r_out_last <= r_s2_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

### src/cross_mean_blur_rgb.sv
// ----------------------------------------------------------------------------
// cross_mean_blur_rgb - five point cross mean blur over an RGB raster stream
// Front classifies requests and tracks position, a queue decouples it from
// the back end, which keeps two row stores and computes the floor mean.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                        payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata rgb, tuser op
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata rgb, tlast end
// cfg       in         i_cfg_valid/o_cfg_ready          index, data
//
// One request per clock sustained while the output is not blocked; each row
// store takes one write per clock, which sets that figure. An accepted request
// passes the queue, stage 1, stage 2 and the output register. Output lags
// input by one row; flush requests drain the last row of the frame.
// Synchronous active low reset clears position and handshake state; the row
// stores are not cleared and need no clearing pass.
// A blocked output stalls the back end; the front keeps accepting until the
// four entry queue fills.
// ----------------------------------------------------------------------------
module cross_mean_blur_rgb
    import cmb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input pixel stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [PIX_W-1:0]      i_s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                  i_s_axis_tuser,  // op
    // output pixel stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [PIX_W-1:0]      o_m_axis_tdata,  // red_out, green_out, blue_out
    output logic                  o_m_axis_tlast,  // last_of_frame
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int QW  = CW + PIX_W + FLAGS_W;

    // front to queue
    logic             f_push;
    logic [CW-1:0]    f_col;
    logic [PIX_W-1:0] f_pix;
    t_cmd_flags       f_flags;
    logic             q_full, q_empty, q_pop;
    logic [QW-1:0]    q_wr_data, q_rd_data;

    // queue head to back end
    logic [CW-1:0]    b_col;
    logic [PIX_W-1:0] b_pix;
    t_cmd_flags       b_flags;

    cmb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_push          (f_push),
        .o_col           (f_col),
        .o_pix           (f_pix),
        .o_flags         (f_flags),
        .i_full          (q_full)
    );

    assign q_wr_data = {f_col, f_pix, f_flags};

    cmb_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    assign b_flags = t_cmd_flags'(q_rd_data[FLAGS_W-1:0]);
    assign b_pix   = q_rd_data[FLAGS_W +: PIX_W];
    assign b_col   = q_rd_data[FLAGS_W + PIX_W +: CW];

    cmb_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_col   (b_col),
        .i_pix   (b_pix),
        .i_flags (b_flags),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

### src/cmb_checker.sv
// ----------------------------------------------------------------------------
// cmb_checker - port level checks for the blur block
// Reset state, output hold under stall and frame end spacing.
// ----------------------------------------------------------------------------
`include "cross_mean_blur_rgb_assert.svh"

module cmb_checker
    import cmb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [PIX_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast,
    input logic             o_cfg_ready
);

    // a stalled result holds
    `CMB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    // the next frame needs a stored row before any result, so a gap follows the end
    `CMB_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, !o_m_axis_tvalid)

    `CMB_ASSERT_RST(a_rst_out, i_clk, i_rst_n, !o_m_axis_tvalid)

    // queue empty after reset, so both request channels are open
    `CMB_ASSERT_RST(a_rst_ready, i_clk, i_rst_n, o_s_axis_tready && o_cfg_ready)

endmodule

bind cross_mean_blur_rgb cmb_checker u_cmb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_cfg_ready     (o_cfg_ready)
);
